FILE: design/bbb_pkg.sv
// Shared types, widths and constants for the 3x3 box blur blend block.
// Used by the window cell, the divide-and-blend unit and the top level.
// No dependencies.
package bbb_pkg;

	localparam int MAX_SIDE   = 64;
	localparam int PIXEL_BITS = 24;

	localparam int SIDE_W     = 7;
	localparam int WEIGHT_W   = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int ADDR_BITS  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int ADDR_W     = (ADDR_BITS > SIDE_W) ? SIDE_W : ADDR_BITS;

	localparam int WIN_ROWS   = 3;
	localparam int WIN_COLS   = 3;
	localparam int NUM_CENTRES = 4;

	localparam int COLSUM_W   = PIXEL_BITS + 2;
	localparam int SUM_W      = PIXEL_BITS + 4;
	localparam int MAG_W      = PIXEL_BITS + 4;
	localparam int COUNT_W    = 4;
	localparam int RECIP_K    = MAG_W;
	localparam int RECIP_W    = RECIP_K + 1;
	localparam int PROD_W     = MAG_W + RECIP_W;
	localparam int DIFF_W     = PIXEL_BITS + 1;
	localparam int BPROD_W    = DIFF_W + WEIGHT_W + 1;

	localparam logic [WEIGHT_W-1:0] WEIGHT_CAP = WEIGHT_W'(52429);
	localparam logic [SIDE_W-1:0]   SIDE_RESET = SIDE_W'(16);

	localparam logic [CFG_IDX_W-1:0] CFG_SIDE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = CFG_IDX_W'(1);

	typedef logic signed [PIXEL_BITS-1:0] pix_t;
	typedef logic signed [COLSUM_W-1:0]   colsum_t;
	typedef logic signed [SUM_W-1:0]      sum_t;
	typedef logic [MAG_W-1:0]             mag_t;
	typedef logic [RECIP_W-1:0]           recip_t;
	typedef logic [PROD_W-1:0]            prod_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [BPROD_W-1:0]    bprod_t;
	typedef logic [COUNT_W-1:0]           count_t;
	typedef logic [WEIGHT_W-1:0]          weight_t;
	typedef logic [SIDE_W-1:0]            side_t;
	typedef logic [ADDR_W-1:0]            addr_t;
	typedef logic [WIN_COLS-1:0]          col_mask_t;
	typedef logic [WIN_ROWS-1:0]          row_mask_t;

	localparam recip_t RECIP_1 = RECIP_W'((longint'(1) << RECIP_K) / 1);
	localparam recip_t RECIP_2 = RECIP_W'((longint'(1) << RECIP_K) / 2);
	localparam recip_t RECIP_3 = RECIP_W'((longint'(1) << RECIP_K) / 3);
	localparam recip_t RECIP_4 = RECIP_W'((longint'(1) << RECIP_K) / 4);
	localparam recip_t RECIP_6 = RECIP_W'((longint'(1) << RECIP_K) / 6);
	localparam recip_t RECIP_9 = RECIP_W'((longint'(1) << RECIP_K) / 9);

	typedef struct packed {
		pix_t top;
		pix_t mid;
	} line_word_t;

	typedef struct packed {
		pix_t      centre;
		count_t    count;
		col_mask_t col_mask;
		weight_t   weight;
		logic      run_last;
		logic      patch_last;
	} blend_req_t;

	typedef struct packed {
		pix_t value;
		logic run_last;
		logic patch_last;
	} blend_res_t;

	// Reciprocal of the neighbor count, floor(2^RECIP_K / n); counts are products of 1..3.
	function automatic recip_t recip_of(input count_t n);
		recip_t r;
		case (n)
			COUNT_W'(1): r = RECIP_1;
			COUNT_W'(2): r = RECIP_2;
			COUNT_W'(3): r = RECIP_3;
			COUNT_W'(4): r = RECIP_4;
			COUNT_W'(6): r = RECIP_6;
			COUNT_W'(9): r = RECIP_9;
			default:     r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: design/bbb_cell.sv
// One column cell of the 3x3 window: holds three pixels and a masked column sum.
// Hands its column to the left neighbor on every shift.
// Depends on bbb_pkg.
module bbb_cell (
	input  logic                           clk,
	input  logic                           shift_en,
	input  bbb_pkg::pix_t                  col_in [bbb_pkg::WIN_ROWS],
	input  logic                           sum_en,
	input  logic [bbb_pkg::WIN_ROWS-1:0]   row_mask,
	output bbb_pkg::pix_t                  col_out [bbb_pkg::WIN_ROWS],
	output bbb_pkg::colsum_t               sum_out
);
	import bbb_pkg::*;

	pix_t    col_q [WIN_ROWS];
	colsum_t sum_q;
	colsum_t sum_c;

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < WIN_ROWS; i++) begin
			if (row_mask[i]) begin
				sum_c = sum_c + COLSUM_W'(col_q[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			col_q <= col_in;
		end
		if (sum_en) begin
			sum_q <= sum_c;
		end
	end

	assign col_out = col_q;
	assign sum_out = sum_q;

endmodule

FILE: design/bbb_blend.sv
// Eight-stage mean and blend unit: masked window sum, rounded division by the
// neighbor count through a constant reciprocal, then weighted blend with the centre.
// Depends on bbb_pkg.
module bbb_blend (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  bbb_pkg::blend_req_t  req,
	input  bbb_pkg::colsum_t     col_sum [bbb_pkg::WIN_COLS],
	output logic                 done,
	output bbb_pkg::blend_res_t  res
);
	import bbb_pkg::*;

	blend_req_t req_q;
	logic       v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	sum_t       total_s1;
	sum_t       total_c;
	logic       neg_s2;
	mag_t       m_s2, m_s3;
	mag_t       mag_c;
	prod_t      prod_s3;
	mag_t       q0_s4, rem_s4;
	mag_t       q_s5;
	diff_t      mean_c;
	diff_t      d_s6;
	bprod_t     p_s7;
	bprod_t     pr_c;
	bprod_t     sh_c;
	blend_res_t res_s8;

	always_comb begin
		total_c = '0;
		for (int j = 0; j < WIN_COLS; j++) begin
			if (req.col_mask[j]) begin
				total_c = total_c + SUM_W'(col_sum[j]);
			end
		end
	end

	assign mag_c  = total_s1[SUM_W-1] ? MAG_W'(-total_s1) : MAG_W'(total_s1);
	assign mean_c = neg_s2 ? -$signed(DIFF_W'(q_s5)) : $signed(DIFF_W'(q_s5));
	assign pr_c   = p_s7 + BPROD_W'(1 << (WEIGHT_W - 1));
	assign sh_c   = pr_c >>> WEIGHT_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			req_q    <= req;
			total_s1 <= total_c;
		end
		if (v_s1) begin
			neg_s2 <= total_s1[SUM_W-1];
			m_s2   <= mag_c + MAG_W'(req_q.count >> 1);
		end
		if (v_s2) begin
			prod_s3 <= PROD_W'(m_s2) * PROD_W'(recip_of(req_q.count));
			m_s3    <= m_s2;
		end
		if (v_s3) begin
			q0_s4  <= MAG_W'(prod_s3[PROD_W-1:RECIP_K]);
			rem_s4 <= m_s3 - MAG_W'(MAG_W'(prod_s3[PROD_W-1:RECIP_K]) * MAG_W'(req_q.count));
		end
		if (v_s4) begin
			q_s5 <= (rem_s4 >= MAG_W'(req_q.count)) ? q0_s4 + MAG_W'(1) : q0_s4;
		end
		if (v_s5) begin
			d_s6 <= mean_c - DIFF_W'(req_q.centre);
		end
		if (v_s6) begin
			p_s7 <= BPROD_W'(d_s6) * $signed(BPROD_W'({1'b0, req_q.weight}));
		end
		if (v_s7) begin
			res_s8.value      <= req_q.centre + sh_c[PIXEL_BITS-1:0];
			res_s8.run_last   <= req_q.run_last;
			res_s8.patch_last <= req_q.patch_last;
		end
	end

	assign done = v_s8;
	assign res  = res_s8;

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8}))
		else $error("more than one item in the blend pipeline");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !(v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || v_s6 || v_s7 || v_s8))
		else $error("blend started while busy");
	a_count_valid: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (req_q.count != '0))
		else $error("zero neighbor count in divide stage");
`endif

endmodule

FILE: design/box_blur_blend_3x3_top.sv
// Top level of the 3x3 box blur blend block: line store, window cell chain,
// position counters, result sequencer and output register.
// Depends on bbb_pkg, bbb_cell and bbb_blend.
//
// Usage: pixels of a square patch enter in raster order on in_valid/in_ready
// (pixel_value). Results leave in raster order on out_valid/out_ready with
// smoothed_value, run_last (last result caused by that input item) and
// patch_last (result for the patch's final pixel). Registers are written on
// wr_en/wr_index/wr_data; the user must write them only while the block is
// idle, which the block itself does not enforce: index 0 is side_length
// (restarts the patch), index 1 is blend_weight (Q0.16, capped at 0.8). An
// item yields 0 to 4 results, each computed in turn by the single eight-stage
// divide-and-blend unit that all results of an item share. One item is in
// work at a time. Reset clears the counters, side_length to 16 and
// blend_weight to 0; the line store needs no clearing. When the receiver
// stalls, the output register holds its item and the sequencer waits before
// starting the next result; an input item is still taken while a finished
// result waits.
module box_blur_blend_3x3_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  bbb_pkg::pix_t                     pixel_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output bbb_pkg::pix_t                     smoothed_value,
	output logic                              run_last,
	output logic                              patch_last,
	input  logic                              wr_en,
	input  logic [bbb_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [bbb_pkg::CFG_DATA_W-1:0]    wr_data
);
	import bbb_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SHIFT = 4'b0010,
		S_SUM   = 4'b0100,
		S_WAIT  = 4'b1000
	} state_t;

	state_t     state_q;
	side_t      side_q;
	weight_t    weight_q;
	side_t      col_q, row_q;
	side_t      r_q, c_q;
	pix_t       px_q;
	logic [NUM_CENTRES-1:0] pend_q;
	logic       start_q;
	blend_req_t req_q;

	logic       out_valid_q;
	pix_t       smoothed_q;
	logic       run_last_q;
	logic       patch_last_q;

	line_word_t line_mem [MAX_SIDE];
	line_word_t line_rd_q;

	side_t      s_eff, s_m1;
	side_t      r_w, c_w;
	side_t      c_inc, r_inc;
	logic       accept;
	logic [NUM_CENTRES-1:0] pend_c;
	logic [1:0] k_c;
	logic [NUM_CENTRES-1:0] pend_left;
	row_mask_t  rm_c;
	col_mask_t  cm_c;
	logic [1:0] rcnt_c, ccnt_c;
	logic [1:0] ci_c;
	logic [1:0] cj_c;
	weight_t    w_eff;

	pix_t       col_chain [WIN_COLS+1][WIN_ROWS];
	colsum_t    col_sum [WIN_COLS];
	logic       shift_en, sum_en;
	logic       blend_done;
	blend_res_t blend_res;

	// effective side and wrapped position
	always_comb begin
		if (side_q == '0) begin
			s_eff = SIDE_W'(1);
		end else if (32'(side_q) > MAX_SIDE) begin
			s_eff = SIDE_W'(MAX_SIDE);
		end else begin
			s_eff = side_q;
		end
		s_m1 = s_eff - SIDE_W'(1);
		if (row_q >= s_eff || col_q >= s_eff) begin
			r_w = '0;
			c_w = '0;
		end else begin
			r_w = row_q;
			c_w = col_q;
		end
		c_inc = c_w + SIDE_W'(1);
		r_inc = r_w + SIDE_W'(1);
		pend_c[0] = (r_w >= SIDE_W'(1)) && (c_w >= SIDE_W'(1));
		pend_c[1] = (r_w >= SIDE_W'(1)) && (c_w == s_m1);
		pend_c[2] = (r_w == s_m1) && (c_w >= SIDE_W'(1));
		pend_c[3] = (r_w == s_m1) && (c_w == s_m1);
	end

	// first pending centre and its window masks
	always_comb begin
		if (pend_q[0]) begin
			k_c = 2'd0;
		end else if (pend_q[1]) begin
			k_c = 2'd1;
		end else if (pend_q[2]) begin
			k_c = 2'd2;
		end else begin
			k_c = 2'd3;
		end
		pend_left = pend_q & ~(NUM_CENTRES'(1) << k_c);
		ci_c = k_c[1] ? 2'd2 : 2'd1;
		cj_c = k_c[0] ? 2'd2 : 2'd1;
		rm_c = {1'b1, r_q >= SIDE_W'(1), !k_c[1] && (r_q >= SIDE_W'(2))};
		cm_c = {1'b1, c_q >= SIDE_W'(1), !k_c[0] && (c_q >= SIDE_W'(2))};
		rcnt_c = 2'(rm_c[0]) + 2'(rm_c[1]) + 2'(rm_c[2]);
		ccnt_c = 2'(cm_c[0]) + 2'(cm_c[1]) + 2'(cm_c[2]);
		w_eff = (weight_q > WEIGHT_CAP) ? WEIGHT_CAP : weight_q;
	end

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign shift_en = (state_q == S_SHIFT);
	assign sum_en   = (state_q == S_SUM) && !out_valid_q;

	// line store: two previous rows packed per column
	always_ff @(posedge clk) begin
		if (accept) begin
			line_rd_q <= line_mem[c_w[ADDR_W-1:0]];
		end
		if (shift_en) begin
			line_mem[c_q[ADDR_W-1:0]] <= '{top: line_rd_q.mid, mid: px_q};
		end
	end

	assign col_chain[WIN_COLS][0] = line_rd_q.top;
	assign col_chain[WIN_COLS][1] = line_rd_q.mid;
	assign col_chain[WIN_COLS][2] = px_q;

	for (genvar j = 0; j < WIN_COLS; j++) begin : g_cell
		bbb_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.col_in   (col_chain[j+1]),
			.sum_en   (sum_en),
			.row_mask (rm_c),
			.col_out  (col_chain[j]),
			.sum_out  (col_sum[j])
		);
	end

	bbb_blend u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.req     (req_q),
		.col_sum (col_sum),
		.done    (blend_done),
		.res     (blend_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			side_q      <= SIDE_RESET;
			weight_q    <= '0;
			col_q       <= '0;
			row_q       <= '0;
			pend_q      <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= sum_en;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pend_q  <= pend_c;
						state_q <= S_SHIFT;
						if (c_inc >= s_eff) begin
							col_q <= '0;
							row_q <= (r_inc >= s_eff) ? '0 : r_inc;
						end else begin
							col_q <= c_inc;
							row_q <= r_w;
						end
					end
				end
				S_SHIFT: begin
					state_q <= (pend_q != '0) ? S_SUM : S_IDLE;
				end
				S_SUM: begin
					if (!out_valid_q) begin
						pend_q  <= pend_left;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (blend_done) begin
						out_valid_q <= 1'b1;
						state_q     <= (pend_q != '0) ? S_SUM : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (wr_en && wr_index == CFG_SIDE) begin
				side_q <= wr_data[SIDE_W-1:0];
				col_q  <= '0;
				row_q  <= '0;
			end
			if (wr_en && wr_index == CFG_WEIGHT) begin
				weight_q <= wr_data[WEIGHT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= pixel_value;
			r_q  <= r_w;
			c_q  <= c_w;
		end
		if (sum_en) begin
			req_q.centre     <= col_chain[cj_c][ci_c];
			req_q.count      <= COUNT_W'({2'b00, rcnt_c} * {2'b00, ccnt_c});
			req_q.col_mask   <= cm_c;
			req_q.weight     <= w_eff;
			req_q.run_last   <= (pend_left == '0);
			req_q.patch_last <= (k_c == 2'd3);
		end
		if (blend_done) begin
			smoothed_q   <= blend_res.value;
			run_last_q   <= blend_res.run_last;
			patch_last_q <= blend_res.patch_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign smoothed_value = smoothed_q;
	assign run_last       = run_last_q;
	assign patch_last     = patch_last_q;

`ifndef SYNTHESIS
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		blend_done |-> (state_q == S_WAIT) && !out_valid_q)
		else $error("blend result with no free output register");
	a_ready_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (pend_q == '0))
		else $error("input taken with results still pending");
	a_patch_last_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && patch_last) |-> run_last)
		else $error("patch end not marked as last result of its item");
	a_start_after_sum: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> $past(sum_en))
		else $error("blend started without fresh column sums");
`endif

endmodule

FILE: tb/sv/box_blur_blend_3x3_top_tb.sv
// Self-checking testbench for box_blur_blend_3x3_top: drives pixel patches, writes
// the side and weight registers, and checks every blended result field by field.
// Depends on bbb_pkg and the box_blur_blend_3x3_top RTL.
`timescale 1ns / 100ps

module box_blur_blend_3x3_top_tb;
	import bbb_pkg::*;

	localparam int LIMIT_CYCLES   = 400000;
	localparam int SETTLE_CYCLES  = 50;
	localparam int RANDOM_ITEMS   = 270;
	localparam int STEADY_FROM    = 120;
	localparam int STEADY_TO      = 190;
	localparam int SIDE_OVERRANGE = 127;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);
	localparam pix_t PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
	localparam pix_t PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

	class blur_checker;
		pix_t       line_mem[2*MAX_SIDE];
		pix_t       win[9];
		int         col_pos;
		int         row_pos;
		side_t      side_reg;
		weight_t    weight_reg;
		blend_res_t pending[$];
		int         errors;
		int         pixels;
		int         results;
		int         writes;
		int         widest;

		function new();
			foreach (line_mem[i]) line_mem[i] = '0;
			foreach (win[i]) win[i] = '0;
			col_pos = 0;
			row_pos = 0;
			side_reg = SIDE_RESET;
			weight_reg = '0;
			errors = 0;
			pixels = 0;
			results = 0;
			writes = 0;
			widest = 0;
		endfunction

		function int eff_side();
			if (side_reg == 0) return 1;
			if (side_reg > MAX_SIDE) return MAX_SIDE;
			return side_reg;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			writes++;
			if (idx == CFG_SIDE) begin
				side_reg = data[SIDE_W-1:0];
				col_pos = 0;
				row_pos = 0;
			end else if (idx == CFG_WEIGHT) begin
				weight_reg = data[WEIGHT_W-1:0];
			end
		endfunction

		function pix_t blend_centre(int ci, int cj, int r, int c, int s);
			longint sum, cnt, centre, mean, q, d, w;
			int ar, ac;
			sum = 0;
			cnt = 0;
			for (int i = ci - 1; i <= ci + 1; i++) begin
				ar = r - 2 + i;
				if (i < 0 || i > 2 || ar < 0 || ar >= s) continue;
				for (int j = cj - 1; j <= cj + 1; j++) begin
					ac = c - 2 + j;
					if (j < 0 || j > 2 || ac < 0 || ac >= s) continue;
					sum += win[i*3+j];
					cnt++;
				end
			end
			centre = win[ci*3+cj];
			if (cnt == 0) return pix_t'(centre);
			q = ((sum < 0 ? -sum : sum) + cnt / 2) / cnt;
			mean = (sum < 0) ? -q : q;
			w = (weight_reg > WEIGHT_CAP) ? WEIGHT_CAP : weight_reg;
			d = mean - centre;
			return pix_t'(centre + ((w * d + 32768) >>> 16));
		endfunction

		function void note_pixel(pix_t px);
			int s, r, c, n;
			int ci[4];
			int cj[4];
			pix_t top, mid;
			blend_res_t res;
			s = eff_side();
			if (s > widest) widest = s;
			pixels++;
			if (row_pos >= s || col_pos >= s) begin
				row_pos = 0;
				col_pos = 0;
			end
			r = row_pos;
			c = col_pos;
			top = line_mem[c];
			mid = line_mem[MAX_SIDE+c];
			line_mem[c] = mid;
			line_mem[MAX_SIDE+c] = px;
			for (int k = 0; k < 3; k++) begin
				win[k*3]   = win[k*3+1];
				win[k*3+1] = win[k*3+2];
			end
			win[2] = top;
			win[5] = mid;
			win[8] = px;
			n = 0;
			if (r >= 1 && c >= 1) begin ci[n] = 1; cj[n] = 1; n++; end
			if (r >= 1 && c == s - 1) begin ci[n] = 1; cj[n] = 2; n++; end
			if (r == s - 1 && c >= 1) begin ci[n] = 2; cj[n] = 1; n++; end
			if (r == s - 1 && c == s - 1) begin ci[n] = 2; cj[n] = 2; n++; end
			for (int k = 0; k < n; k++) begin
				res.value = blend_centre(ci[k], cj[k], r, c, s);
				res.run_last = (k == n - 1);
				res.patch_last = (r == s - 1 && c == s - 1 && ci[k] == 2 && cj[k] == 2);
				pending.push_back(res);
			end
			col_pos++;
			if (col_pos >= s) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= s) row_pos = 0;
			end
		endfunction

		task report(string msg);
			if (errors < 40) $display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(pix_t v, logic rl, logic pl);
			blend_res_t e;
			if (pending.size() == 0) begin
				report($sformatf("result %0d with nothing expected", v));
				return;
			end
			e = pending.pop_front();
			results++;
			if (v !== e.value)
				report($sformatf("result %0d smoothed_value %0d, want %0d", results, v, e.value));
			if (rl !== e.run_last)
				report($sformatf("result %0d run_last %b, want %b", results, rl, e.run_last));
			if (pl !== e.patch_last)
				report($sformatf("result %0d patch_last %b, want %b", results, pl, e.patch_last));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	pix_t                 pixel_value;
	logic                 out_valid;
	logic                 out_ready;
	pix_t                 smoothed_value;
	logic                 run_last;
	logic                 patch_last;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	blur_checker sb;
	logic        steady;
	int          driven;
	int          cycle_count;

	box_blur_blend_3x3_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.pixel_value    (pixel_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.smoothed_value (smoothed_value),
		.run_last       (run_last),
		.patch_last     (patch_last),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(negedge clk) begin
		out_ready = steady || ($urandom_range(0, 99) >= 36);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_pixel(pixel_value);
			if (out_valid && out_ready) sb.check_result(smoothed_value, run_last, patch_last);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("box_blur_blend_3x3_top_tb NOT OK");
		$finish;
	end

	function pix_t rand_pix();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) return PIX_MAX;
		if (pick < 16) return PIX_MIN;
		if (pick < 26) return pix_t'($urandom_range(0, 8)) - pix_t'(4);
		return pix_t'($urandom);
	endfunction

	function logic [CFG_DATA_W-1:0] pick_weight();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return WEIGHT_CAP;
			2: return CFG_DATA_W'($urandom_range(WEIGHT_CAP + 1, 65535));
			3: return CFG_DATA_W'($urandom_range(1, 255));
			default: return CFG_DATA_W'($urandom_range(0, WEIGHT_CAP));
		endcase
	endfunction

	function int pick_side();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) return 0;
		if (pick == 1) return 1;
		if (pick < 4) return $urandom_range(7, 12);
		return $urandom_range(2, 6);
	endfunction

	task send_pixel(pix_t px);
		steady = (driven >= STEADY_FROM && driven < STEADY_TO);
		while (!steady && $urandom_range(0, 99) < 36) begin
			in_valid = 1'b0;
			pixel_value = pix_t'($urandom);
			@(negedge clk);
		end
		in_valid = 1'b1;
		pixel_value = px;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		driven++;
	endtask

	task send_run(int n);
		for (int i = 0; i < n; i++) send_pixel(rand_pix());
	endtask

	task drain();
		in_valid = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		drain();
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = data;
		sb.set_reg(idx, data);
		@(negedge clk);
		wr_en = 1'b0;
		wr_index = CFG_IDX_W'($urandom);
		wr_data = CFG_DATA_W'($urandom);
	endtask

	task set_side(int s);
		logic [CFG_DATA_W-1:0] data;
		data = CFG_DATA_W'($urandom);
		data[SIDE_W-1:0] = SIDE_W'(s);
		write_reg(CFG_SIDE, data);
	endtask

	initial begin
		int s, n, pick;
		bit wide_done, over_done;
		in_valid = 1'b0;
		pixel_value = '0;
		out_ready = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		steady = 1'b0;
		driven = 0;
		wide_done = 0;
		over_done = 0;
		arst_n = 1'b0;
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: side 16, pass-through
		send_run(18);
		set_side(1);
		write_reg(CFG_WEIGHT, '0);
		send_pixel(PIX_MAX);
		send_pixel(PIX_MIN);
		send_pixel('0);
		send_pixel('1);
		write_reg(CFG_WEIGHT, '1);
		set_side(0);
		send_pixel(PIX_MIN);
		send_pixel(PIX_MAX);
		set_side(2);
		write_reg(CFG_WEIGHT, WEIGHT_CAP);
		send_pixel(PIX_MAX);
		send_pixel(PIX_MIN);
		send_pixel(PIX_MIN);
		send_pixel(PIX_MAX);
		write_reg(CFG_SPARE_LO, CFG_DATA_W'(1));
		write_reg(CFG_SPARE_HI, '1);
		set_side(3);
		write_reg(CFG_WEIGHT, CFG_DATA_W'(32768));
		send_pixel(PIX_MAX);
		send_pixel(PIX_MIN);
		send_pixel(PIX_MAX);
		send_pixel(PIX_MIN);
		write_reg(CFG_WEIGHT, CFG_DATA_W'(40000));
		send_run(5);
		send_run(3);
		set_side(2);
		send_run(4);

		n = driven;
		while (driven - n < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (!wide_done && driven - n >= 90) begin
				write_reg(CFG_WEIGHT, pick_weight());
				set_side(MAX_SIDE);
				send_run(2 * MAX_SIDE + 6);
				wide_done = 1;
			end else if (!over_done && driven - n >= 190) begin
				set_side(SIDE_OVERRANGE);
				send_run(MAX_SIDE + 2);
				over_done = 1;
			end else if (pick < 10) begin
				write_reg(CFG_WEIGHT, pick_weight());
				send_run($urandom_range(1, 20));
			end else if (pick < 25) begin
				s = pick_side();
				set_side(s);
				write_reg(CFG_WEIGHT, pick_weight());
				s = (s == 0) ? 1 : s;
				send_run((s == 1) ? 1 : $urandom_range(1, s * s - 1));
			end else begin
				s = pick_side();
				set_side(s);
				write_reg(CFG_WEIGHT, pick_weight());
				s = (s == 0) ? 1 : s;
				repeat ((s >= 7) ? 1 : $urandom_range(1, 3)) begin
					send_run(s * s);
					if ($urandom_range(0, 7) == 0) drain();
				end
			end
		end

		drain();
		$display("run: %0d pixels accepted, %0d results checked, %0d register writes",
			sb.pixels, sb.results, sb.writes);
		$display("sides 1 to %0d with weights 0 to capped, %0d mismatches",
			sb.widest, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("box_blur_blend_3x3_top_tb OK");
		else
			$display("box_blur_blend_3x3_top_tb NOT OK");
		$finish;
	end

endmodule
